[hw/rtl/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 32;

  localparam int BYTE_W = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int SYM_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  // Work word: up to seven pending bits plus one full code word, left-aligned.
  localparam int WK_W  = CODE_W + BYTE_W;
  localparam int TOT_W = $clog2(WK_W + 1);
  localparam int PEND_W = 3;
  localparam int CNT_W  = 2;
  localparam int MAX_BYTES = 4;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_size;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_t;

  typedef struct packed {
    logic              en;
    logic [SYM_W-1:0]  idx;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_wr_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_rd_t;

endpackage

[hw/rtl/hcbp_table.sv]
// ----------------------------------------------------------------------------
// hcbp_table
// Per-symbol code word and code length storage, one write and one
// registered read per cycle. Lengths read as zero until written.
// ----------------------------------------------------------------------------
module hcbp_table import hcbp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tbl_wr_t          wr,
  input  logic [SYM_W-1:0] rd_idx,
  output tbl_rd_t          rd
);

  logic [CODE_W-1:0]      code_mem [NUM_SYMBOLS];
  logic [LEN_W-1:0]       len_mem  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld_r;
  logic [CODE_W-1:0]      code_q_r;
  logic [LEN_W-1:0]       len_q_r;
  logic                   vld_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      code_mem[wr.idx] <= wr.code;
      len_mem[wr.idx]  <= wr.len;
    end
    code_q_r <= code_mem[rd_idx];
    len_q_r  <= len_mem[rd_idx];
  end

  // Valid bits stand in for the all-zero length reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.idx] <= 1'b1;
      end
      vld_q_r <= vld_r[rd_idx];
    end
  end

  assign rd.code = code_q_r;
  assign rd.len  = vld_q_r ? len_q_r : '0;

endmodule

[hw/rtl/huffman_code_bit_packer_top.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Appends per-symbol Huffman codes MSB-first to a bit stream and emits
// completed bytes; flush pads and emits the partial byte.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                         | Beat
//  --------+-------------------------------+----------------------------------
//  input   | in_valid, in_stall, in_data   | load / encode / flush request
//  output  | out_valid, out_stall, out_data| one packed byte plus last flag
//
//  Sequencing: a load writes the table when it is accepted. An encode reads
//  the table through its registered read port, aligns the code in the read
//  state, then shifts out 0..4 bytes, one byte per cycle while the output is
//  not stalled; a flush emits the pending partial byte, if there is one.
//  Reset clears the sequencer, the bit accumulator and all code lengths;
//  code words are unknown until loaded. A stalled output holds the shifter.
//
module huffman_code_bit_packer_top import hcbp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  state_t             state_r;
  logic [WK_W-1:0]    wk_r;       // pending bits then code bits, left-aligned
  logic [TOT_W-1:0]   total_r;    // valid bits in wk_r
  logic [CNT_W-1:0]   cnt_r;      // bytes emitted for this beat
  logic               flush_r;
  logic [BYTE_W-1:0]  acc_r;      // pending bits, left-aligned, zeros below
  logic [PEND_W-1:0]  pend_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic               accept;
  logic               sym_ok;
  logic [LEN_W-1:0]   len_sat;
  logic [CODE_W-1:0]  code_mask;
  tbl_wr_t            tbl_wr;
  tbl_rd_t            tbl_rd;

  logic [LEN_W-1:0]   align_amt;
  logic [CODE_W-1:0]  code_left;
  logic [WK_W-1:0]    wk_new;
  logic [TOT_W-1:0]   total_new;

  logic               out_free;
  logic [WK_W-1:0]    wk_shift;
  logic [TOT_W-1:0]   total_dec;
  logic               emit_last;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign sym_ok   = ({1'b0, in_data.symbol} < 9'(NUM_SYMBOLS));

  // Saturate the loaded length and drop code bits at or above it.
  assign len_sat   = (in_data.code_size > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                            : in_data.code_size;
  assign code_mask = CODE_W'((64'd1 << len_sat) - 64'd1);

  assign tbl_wr.en   = accept && (in_data.req_type == REQ_LOAD) && sym_ok;
  assign tbl_wr.idx  = in_data.symbol[SYM_W-1:0];
  assign tbl_wr.code = in_data.code_value & code_mask;
  assign tbl_wr.len  = len_sat;

  hcbp_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (tbl_wr),
    .rd_idx (in_data.symbol[SYM_W-1:0]),
    .rd     (tbl_rd)
  );

  // Align the code to the top, then slot it in behind the pending bits.
  assign align_amt = LEN_W'(CODE_W) - tbl_rd.len;
  assign code_left = tbl_rd.code << align_amt;
  assign wk_new    = {acc_r, {CODE_W{1'b0}}} | ({code_left, {BYTE_W{1'b0}}} >> pend_r);
  assign total_new = TOT_W'(pend_r) + TOT_W'(tbl_rd.len);

  // Byte shifter: one byte off the top per cycle while the output is not stalled.
  assign out_free  = !out_valid_r || !out_stall;
  assign wk_shift  = wk_r << BYTE_W;
  assign total_dec = total_r - TOT_W'(BYTE_W);
  assign emit_last = flush_r || (total_dec < TOT_W'(BYTE_W))
                     || (cnt_r == CNT_W'(MAX_BYTES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      flush_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // the emit state decides the output register on its own
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cnt_r <= '0;
            if (in_data.req_type == REQ_ENCODE && sym_ok) begin
              flush_r <= 1'b0;
              state_r <= S_READ;
            end else if (in_data.req_type == REQ_FLUSH && pend_r != '0) begin
              flush_r <= 1'b1;
              wk_r    <= {acc_r, {CODE_W{1'b0}}};
              total_r <= TOT_W'(pend_r);
              state_r <= S_EMIT;
            end
          end
        end
        S_READ: begin
          if (tbl_rd.len == '0) begin
            state_r <= S_IDLE;
          end else if (total_new < TOT_W'(BYTE_W)) begin
            // No complete byte: fold into the accumulator.
            acc_r   <= wk_new[WK_W-1 -: BYTE_W];
            pend_r  <= total_new[PEND_W-1:0];
            state_r <= S_IDLE;
          end else begin
            wk_r    <= wk_new;
            total_r <= total_new;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r         <= 1'b1;
            out_data_r.out_byte <= wk_r[WK_W-1 -: BYTE_W];
            out_data_r.last     <= emit_last;
            wk_r                <= wk_shift;
            total_r             <= total_dec;
            cnt_r               <= cnt_r + 1'b1;
            if (emit_last) begin
              if (flush_r) begin
                acc_r  <= '0;
                pend_r <= '0;
              end else begin
                acc_r  <= wk_shift[WK_W-1 -: BYTE_W];
                pend_r <= total_dec[PEND_W-1:0];
              end
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
